/* rtl/core/rrts_pkg.sv */
`default_nettype none
package rrts_pkg;

  localparam int SLOT_COUNT_DEF  = 8;
  localparam int STACK_BYTES_DEF = 4096;

  localparam int CTX_W     = 32;
  localparam int SLOT_ID_W = 3;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_EXIT   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SLOT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SWITCH = 2'd2;

  localparam logic [CTX_W-1:0] CTX_OFFSET = 32'd24;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DEAD    = 2'd3
  } slot_state_t;

endpackage
`default_nettype wire

/* rtl/core/rrts_ram.sv */
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/round_robin_task_scheduler_unit.sv */
// Round-robin task-slot scheduler. A transaction is taken when start is high
// and busy is low; opcode selects create (take the lowest unused slot, give
// it the initial context base + (slot+1)*STACK_BYTES - 24), tick (search
// round-robin after the current slot for a ready or running slot and switch
// to it, saving live_context for the previous slot) or exit (mark the
// current slot dead); the unused opcode is answered like an exit but
// marks no slot. Exactly one result comes back per transaction, shown
// for a single cycle with done high; the receiver cannot stall it and must
// take it in that cycle. Slot state is checked one slot per clock. A create
// registers done from the scan once it finds an unused slot or has seen
// every slot; a tick that switches goes from the scan through S_SWAP (save
// the old context) and S_LOAD (registered context memory read) to done, a
// tick without a switch strobes when its scan ends, and an exit strobes in
// the next cycle. busy is low again in the cycle done is high, so the next
// transaction may start then. stack_region_base is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, unchecked.
`default_nettype none
module round_robin_task_scheduler_unit #(
  parameter int SLOT_COUNT  = rrts_pkg::SLOT_COUNT_DEF,
  parameter int STACK_BYTES = rrts_pkg::STACK_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [rrts_pkg::CTX_W-1:0]     cfg_wr_data,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rrts_pkg::OP_W-1:0]      opcode,
  input  wire logic [rrts_pkg::CTX_W-1:0]     live_context,
  output logic                                done,
  output logic      [rrts_pkg::STAT_W-1:0]    status,
  output logic      [rrts_pkg::SLOT_ID_W-1:0] slot,
  output logic                                had_previous,
  output logic      [rrts_pkg::SLOT_ID_W-1:0] previous_slot,
  output logic      [rrts_pkg::CTX_W-1:0]     load_context,
  output logic      [rrts_pkg::SLOT_ID_W-1:0] current_id
);

  import rrts_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam logic [IW-1:0]    LAST_IDX  = IW'(SLOT_COUNT - 1);
  localparam logic [CTX_W-1:0] CTX_STEP  = CTX_W'(STACK_BYTES);
  localparam logic [CTX_W-1:0] CTX_FIRST = CTX_STEP - CTX_OFFSET;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SWAP = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t            state;
  logic [OP_W-1:0]   op;
  logic [CTX_W-1:0]  live;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     count;
  logic [CTX_W-1:0]  ctx;
  logic [CTX_W-1:0]  base;
  slot_state_t       slot_st [SLOT_COUNT];
  logic [IW-1:0]     cur;
  logic              cur_valid;

  logic [IW-1:0]     st_addr;
  slot_state_t       st_rd;
  logic              runnable;
  logic              last;
  logic [IW-1:0]     idx_inc;
  logic [IW-1:0]     cur_inc;
  logic [SLOT_ID_W-1:0] cur_id;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [CTX_W-1:0]  ram_wdata;
  logic [CTX_W-1:0]  ram_rdata;

  assign busy     = (state != S_IDLE);
  assign st_addr  = (state == S_SWAP) ? cur : idx;
  assign st_rd    = slot_st[st_addr];
  assign runnable = (st_rd == ST_READY) || (st_rd == ST_RUNNING);
  assign last     = (count == LAST_IDX);
  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign cur_inc  = (cur == LAST_IDX) ? '0 : cur + 1'b1;
  assign cur_id   = cur_valid ? SLOT_ID_W'(cur) : '0;

  assign ram_we    = ((state == S_SCAN) && (op == OP_CREATE) && (st_rd == ST_UNUSED))
                   || ((state == S_SWAP) && cur_valid);
  assign ram_waddr = (state == S_SWAP) ? cur : idx;
  assign ram_wdata = (state == S_SWAP) ? live : ctx;

  rrts_ram #(
    .WIDTH (CTX_W),
    .DEPTH (SLOT_COUNT)
  ) u_ctx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_wr_en) begin
      base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      cur       <= '0;
      cur_valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_st[i] <= ST_UNUSED;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op    <= opcode;
            live  <= live_context;
            count <= '0;
            priority if (opcode == OP_CREATE) begin
              idx   <= '0;
              ctx   <= base + CTX_FIRST;
              state <= S_SCAN;
            end else if (opcode == OP_TICK) begin
              idx   <= cur_valid ? cur_inc : '0;
              state <= S_SCAN;
            end else begin
              if ((opcode == OP_EXIT) && cur_valid) begin
                slot_st[cur] <= ST_DEAD;
              end
              done          <= 1'b1;
              status        <= STAT_DONE;
              slot          <= '0;
              had_previous  <= 1'b0;
              previous_slot <= '0;
              load_context  <= '0;
              current_id    <= cur_id;
            end
          end
        end
        S_SCAN: begin
          if (op == OP_CREATE) begin
            priority if (st_rd == ST_UNUSED) begin
              slot_st[idx]  <= ST_READY;
              done          <= 1'b1;
              status        <= STAT_DONE;
              slot          <= SLOT_ID_W'(idx);
              had_previous  <= 1'b0;
              previous_slot <= '0;
              load_context  <= ctx;
              current_id    <= cur_id;
              state         <= S_IDLE;
            end else if (last) begin
              done          <= 1'b1;
              status        <= STAT_NO_SLOT;
              slot          <= '0;
              had_previous  <= 1'b0;
              previous_slot <= '0;
              load_context  <= '0;
              current_id    <= cur_id;
              state         <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              count <= count + 1'b1;
              ctx   <= ctx + CTX_STEP;
            end
          end else begin
            priority if (runnable && !(cur_valid && (idx == cur))) begin
              state <= S_SWAP;
            end else if (runnable || last) begin
              done          <= 1'b1;
              status        <= STAT_NO_SWITCH;
              slot          <= '0;
              had_previous  <= 1'b0;
              previous_slot <= '0;
              load_context  <= '0;
              current_id    <= cur_id;
              state         <= S_IDLE;
            end else begin
              idx   <= idx_inc;
              count <= count + 1'b1;
            end
          end
        end
        S_SWAP: begin
          if (cur_valid && (st_rd == ST_RUNNING)) begin
            slot_st[cur] <= ST_READY;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          slot_st[idx]  <= ST_RUNNING;
          cur           <= idx;
          cur_valid     <= 1'b1;
          done          <= 1'b1;
          status        <= STAT_DONE;
          slot          <= SLOT_ID_W'(idx);
          had_previous  <= cur_valid;
          previous_slot <= cur_id;
          load_context  <= ram_rdata;
          current_id    <= SLOT_ID_W'(idx);
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an accepted transaction either keeps the unit busy or answers at once
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor answered");

  // a result never shows while a transaction is still in flight
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a saved previous context only comes with a completed switch
  assert property (@(posedge clk) disable iff (rst)
    (done && had_previous) |-> (status == STAT_DONE && current_id == slot))
    else $error("previous task reported without a switch");

  // failed requests carry no slot and no context
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_NO_SLOT || status == STAT_NO_SWITCH))
      |-> (slot == '0 && load_context == '0 && !had_previous))
    else $error("failed request carries payload");

endmodule
`default_nettype wire
